// ----- hdl/blkch_pkg.sv -----
`timescale 1ns / 1ps
// Package for the blocked channel table: operation codes and request/result structs.
// No dependencies; imported by blocked_channel_table, its checker and the testbench.
package blkch_pkg;

  localparam int HASH_W  = 8;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [HASH_W-1:0] channel_hash;
  } req_t;

  typedef struct packed {
    logic               success;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

endpackage

// ----- hdl/blocked_channel_table.sv -----
`timescale 1ns / 1ps
// Blocked channel table: a request is accepted when start is high and busy is low.
// The request is registered into req_valid and req_q, and done and the result are registered
// from them. The receiver cannot stall; done lasts one cycle per request.
// Throughput: one request per cycle while busy is low; every live slot is compared in parallel.
// Reset: synchronous; clears the live count, req_valid and done; busy is high while rst is high.
// Depends on blkch_pkg.
module blocked_channel_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  blkch_pkg::req_t request,
  output logic           done,
  output blkch_pkg::rsp_t result
);
  import blkch_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  logic [HASH_W-1:0] hash_entries [TABLE_DEPTH];
  logic [CNT_W-1:0]  live_count;
  logic [CNT_W-1:0]  live_count_next;

  logic              req_valid;
  req_t              req_q;

  logic [TABLE_DEPTH-1:0] match;
  logic                   hit;
  logic                   can_add;
  logic                   do_add;
  logic                   do_delete;
  logic [CNT_W-1:0]       last_count;
  logic [IDX_W-1:0]       last_idx;
  logic [IDX_W-1:0]       tail_idx;
  logic [HASH_W-1:0]      last_entry;
  logic                   success_next;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start;
    end
    req_q <= request;
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = (CNT_W'(i) < live_count) && (hash_entries[i] == req_q.channel_hash);
    end
  end

  assign hit        = |match;
  assign can_add    = live_count < DEPTH_C;
  assign last_count = live_count - CNT_W'(1);
  assign last_idx   = IDX_W'(last_count);
  assign tail_idx   = IDX_W'(live_count);
  assign last_entry = hash_entries[last_idx];

  always_comb begin
    do_add       = 1'b0;
    do_delete    = 1'b0;
    success_next = 1'b0;
    case (req_q.op)
      OP_LOOKUP: begin
        success_next = hit;
      end
      OP_ADD: begin
        do_add       = !hit && can_add;
        success_next = hit || can_add;
      end
      OP_DELETE: begin
        do_delete    = hit;
        success_next = hit;
      end
      default: begin
        success_next = 1'b0;
      end
    endcase
    do_add    = do_add && req_valid;
    do_delete = do_delete && req_valid;
  end

  always_comb begin
    live_count_next = live_count;
    if (do_add) begin
      live_count_next = live_count + CNT_W'(1);
    end else if (do_delete) begin
      live_count_next = last_count;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (do_add && (tail_idx == IDX_W'(i))) begin
        hash_entries[i] <= req_q.channel_hash;
      end else if (do_delete && match[i]) begin
        hash_entries[i] <= last_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      done       <= 1'b0;
    end else begin
      live_count <= live_count_next;
      done       <= req_valid;
    end
    result.success     <= success_next;
    result.entry_count <= COUNT_W'(live_count_next);
  end

endmodule

// ----- hdl/blocked_channel_table_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for blocked_channel_table, attached by the bind below.
// Depends on blkch_pkg.
module blocked_channel_table_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input blkch_pkg::req_t request,
  input logic            done,
  input blkch_pkg::rsp_t result
);
  import blkch_pkg::*;

  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(TABLE_DEPTH);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("request accepted without a result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result strobe without a matching request");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.entry_count <= DEPTH_C))
    else $error("entry count above table depth");

  a_add_fail_full: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(request.op, 2) == OP_ADD) && !result.success)
      |-> (result.entry_count == DEPTH_C))
    else $error("add failed while the table was not full");

  a_delete_room: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(request.op, 2) == OP_DELETE) && result.success)
      |-> (result.entry_count < DEPTH_C))
    else $error("successful delete left the table full");

endmodule

bind blocked_channel_table blocked_channel_table_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .request(request),
  .done   (done),
  .result (result)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for blocked_channel_table: drives lookup/add/delete and reserved-op requests and mirrors
// the blocklist to check every result strobe. Depends on blkch_pkg and the RTL only.
module testbench;
  import blkch_pkg::*;

  localparam int DEPTH = 16;
  localparam int POOL_SIZE = 20;
  localparam int MAX_REPORTS = 10;
  localparam op_t OP_RESERVED = op_t'(2'd3);

  class blocklist_mirror;
    logic [HASH_W-1:0] slots [DEPTH];
    int unsigned live;
    rsp_t predicted_rsp [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned full_rejects;
    int unsigned delete_hits;
    int unsigned peak;

    function new();
      live = 0;
      mismatches = 0;
      checked = 0;
      full_rejects = 0;
      delete_hits = 0;
      peak = 0;
    endfunction

    function void note_request(req_t r);
      int hit;
      rsp_t p;
      hit = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (hit < 0 && i < live && slots[i] == r.channel_hash) hit = i;
      end
      p.success = 1'b0;
      case (r.op)
        OP_LOOKUP: begin
          p.success = (hit >= 0);
        end
        OP_ADD: begin
          if (hit >= 0) begin
            p.success = 1'b1;
          end else if (live < DEPTH) begin
            slots[live] = r.channel_hash;
            live++;
            p.success = 1'b1;
          end else begin
            full_rejects++;
          end
        end
        OP_DELETE: begin
          if (hit >= 0) begin
            slots[hit] = slots[live - 1];
            live--;
            p.success = 1'b1;
            delete_hits++;
          end
        end
        default: ;
      endcase
      p.entry_count = live[COUNT_W-1:0];
      if (live > peak) peak = live;
      predicted_rsp.push_back(p);
    endfunction

    function void report(string what, rsp_t want, rsp_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s: expected success=%0b count=%0d, got success=%0b count=%0d",
                 $time, what, want.success, want.entry_count, got.success, got.entry_count);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (predicted_rsp.size() == 0) begin
        want = '0;
        report("unexpected result", want, got);
        return;
      end
      want = predicted_rsp.pop_front();
      checked++;
      if (got.success !== want.success || got.entry_count !== want.entry_count)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic done;
  rsp_t result;

  blocklist_mirror mirror = new();
  logic [HASH_W-1:0] hash_pool [POOL_SIZE];
  int unsigned sent;

  blocked_channel_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) mirror.check_result(result);
      if (start && !busy) mirror.note_request(request);
    end
  end

  task automatic send_request(input op_t op, input logic [HASH_W-1:0] hash,
                              input int idle_pct);
    req_t r;
    r.op = op;
    r.channel_hash = hash;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      request.channel_hash <= HASH_W'($urandom_range(0, 255));
    end
    @(negedge clk);
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (mirror.predicted_rsp.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [HASH_W-1:0] pick_hash();
    if ($urandom_range(0, 9) == 0) return HASH_W'($urandom_range(0, 255));
    return hash_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic run_random(input int count, input int idle_pct);
    int mode;
    int roll;
    op_t op;
    foreach (hash_pool[i]) hash_pool[i] = HASH_W'($urandom_range(0, 255));
    hash_pool[0] = 8'h00;
    hash_pool[1] = 8'hFF;
    mode = 0;
    for (int n = 0; n < count; n++) begin
      if (n % 30 == 0) mode = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (roll < 15) op = OP_LOOKUP;
      else if (roll < (mode == 0 ? 70 : mode == 1 ? 40 : 56)) op = OP_ADD;
      else if (roll < 97) op = OP_DELETE;
      else op = OP_RESERVED;
      send_request(op, pick_hash(), idle_pct);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(OP_LOOKUP, 8'h00, 0);
    send_request(OP_DELETE, 8'h00, 0);
    send_request(OP_RESERVED, 8'hFF, 0);
    send_request(OP_ADD, 8'h00, 0);
    send_request(OP_ADD, 8'hFF, 0);
    send_request(OP_ADD, 8'hFF, 0);
    send_request(OP_LOOKUP, 8'hFF, 0);
    send_request(OP_LOOKUP, 8'h80, 0);
    send_request(OP_DELETE, 8'hFF, 0);
    for (int i = 1; i < DEPTH; i++) send_request(OP_ADD, 8'(i * 17), 0);
    send_request(OP_ADD, 8'h5A, 0);
    send_request(OP_ADD, 8'h11, 0);
    send_request(OP_DELETE, 8'h00, 0);
    send_request(OP_RESERVED, 8'h11, 0);
    drain();

    run_random(180, 0);
    drain();
    run_random(180, 50);
    drain();
    run_random(180, 6);
    drain();

    $display("Sent %0d requests, checked %0d results; peak count %0d of %0d.",
             sent, mirror.checked, mirror.peak, DEPTH);
    $display("Adds refused while full: %0d, successful deletes: %0d.",
             mirror.full_rejects, mirror.delete_hits);
    if (mirror.mismatches == 0 && mirror.predicted_rsp.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", mirror.mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding", mirror.predicted_rsp.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
